[design/dual_tier_lru_eviction_lists_core_defines.svh]
// Assertion macros shared by the dual tier LRU list modules.
`ifndef DUAL_TIER_LRU_EVICTION_LISTS_CORE_DEFINES_SVH
`define DUAL_TIER_LRU_EVICTION_LISTS_CORE_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define DTL_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define DTL_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DTL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/dtlru_pkg.sv]
// Shared types and constants for the dual tier LRU list block.
package dtlru_pkg;

    localparam int NODE_W          = 10;
    localparam int CMD_W           = 2;
    localparam int IN_USED         = CMD_W + NODE_W + 1;
    localparam int IN_W            = 16;
    localparam int OUT_USED        = 1 + 2 * (NODE_W + 1);
    localparam int OUT_W           = 24;
    localparam int DEF_NODE_COUNT  = 1024;

    localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    typedef struct packed {
        logic              ok;
        logic [NODE_W-1:0] node;
    } link_t;

    typedef struct packed {
        logic clear;
        logic lookup;
        logic check;
        logic unlink;
        logic link_a;
        logic link_b;
        logic load_out;
    } ctl_t;

    typedef struct packed {
        logic clr_last;
        logic err;
        logic is_write;
        logic is_read;
        logic out_free;
    } sts_t;

endpackage

[design/dtlru_datapath.sv]
// Datapath: link memories, list ends, input latch and output register.
`include "dual_tier_lru_eviction_lists_core_defines.svh"
module dtlru_datapath #(
    parameter int NODE_COUNT = dtlru_pkg::DEF_NODE_COUNT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dtlru_pkg::ctl_t             ctl,
    output dtlru_pkg::sts_t             sts,
    input  logic [dtlru_pkg::IN_W-1:0]  in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [dtlru_pkg::OUT_W-1:0] out_data
);
    import dtlru_pkg::*;

    localparam int AW = $clog2(NODE_COUNT);
    typedef logic [AW-1:0] addr_t;

    logic [CMD_W-1:0]  in_cmd;
    logic [NODE_W-1:0] in_node;
    logic              in_tier;
    logic              in_bad;

    logic [CMD_W-1:0]  cmd_reg;
    logic [NODE_W-1:0] node_reg;
    logic              tier_reg;
    logic              pre_err_reg;
    logic              err_reg;

    logic  present_mem [NODE_COUNT];
    link_t prev_mem    [NODE_COUNT];
    link_t next_mem    [NODE_COUNT];
    logic  tier_mem    [NODE_COUNT];

    logic  present_rd_reg;
    link_t prev_rd_reg;
    link_t next_rd_reg;
    logic  tier_rd_reg;

    link_t head_reg  [2];
    link_t head_next [2];
    link_t tail_reg  [2];
    link_t tail_next [2];

    addr_t clr_cnt_reg;
    addr_t in_addr;
    addr_t n_addr;
    link_t self_link;

    logic  prev_we,    next_we,    tier_we,    present_we;
    addr_t prev_addr,  next_addr,  tier_addr,  present_addr;
    link_t prev_wdata, next_wdata;
    logic  tier_wdata, present_wdata;

    logic              out_vld_reg;
    logic [OUT_W-1:0]  out_data_reg;
    logic [NODE_W-1:0] slc_node;
    logic [NODE_W-1:0] tlc_node;

    assign in_cmd  = in_data[CMD_W-1:0];
    assign in_node = in_data[CMD_W +: NODE_W];
    assign in_tier = in_data[CMD_W + NODE_W];
    assign in_bad  = !(in_cmd == CMD_WRITE || in_cmd == CMD_READ || in_cmd == CMD_REMOVE)
                     || (int'(in_node) >= NODE_COUNT);

    assign in_addr   = addr_t'(in_node);
    assign n_addr    = addr_t'(node_reg);
    assign self_link = '{ok: 1'b1, node: node_reg};

    // input latch
    always_ff @(posedge clk)
    begin
        if (ctl.lookup)
        begin
            cmd_reg     <= in_cmd;
            node_reg    <= in_node;
            tier_reg    <= in_tier;
            pre_err_reg <= in_bad;
        end
        if (ctl.check)
        begin
            err_reg <= sts.err;
        end
    end

    // memory port selection
    always_comb
    begin
        prev_we       = 1'b0;
        prev_addr     = in_addr;
        prev_wdata    = '0;
        next_we       = 1'b0;
        next_addr     = in_addr;
        next_wdata    = '0;
        tier_we       = 1'b0;
        tier_addr     = in_addr;
        tier_wdata    = tier_reg;
        present_we    = 1'b0;
        present_addr  = in_addr;
        present_wdata = 1'b0;

        if (ctl.unlink && next_rd_reg.ok)
        begin
            prev_we    = 1'b1;
            prev_addr  = addr_t'(next_rd_reg.node);
            prev_wdata = prev_rd_reg;
        end
        else if (ctl.link_a && head_reg[tier_reg].ok)
        begin
            prev_we    = 1'b1;
            prev_addr  = addr_t'(head_reg[tier_reg].node);
            prev_wdata = self_link;
        end
        else if (ctl.link_b)
        begin
            prev_we    = 1'b1;
            prev_addr  = n_addr;
            prev_wdata = '0;
        end

        if (ctl.unlink && prev_rd_reg.ok)
        begin
            next_we    = 1'b1;
            next_addr  = addr_t'(prev_rd_reg.node);
            next_wdata = next_rd_reg;
        end
        else if (ctl.link_a)
        begin
            next_we    = 1'b1;
            next_addr  = n_addr;
            next_wdata = head_reg[tier_reg];
        end

        if (ctl.link_a)
        begin
            tier_we   = 1'b1;
            tier_addr = n_addr;
        end

        if (ctl.clear)
        begin
            present_we    = 1'b1;
            present_addr  = clr_cnt_reg;
            present_wdata = 1'b0;
        end
        else if (ctl.unlink && cmd_reg == CMD_REMOVE)
        begin
            present_we    = 1'b1;
            present_addr  = n_addr;
            present_wdata = 1'b0;
        end
        else if (ctl.link_a)
        begin
            present_we    = 1'b1;
            present_addr  = n_addr;
            present_wdata = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
            prev_mem[prev_addr] <= prev_wdata;
        else if (ctl.lookup)
            prev_rd_reg <= prev_mem[prev_addr];
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
            next_mem[next_addr] <= next_wdata;
        else if (ctl.lookup)
            next_rd_reg <= next_mem[next_addr];
    end

    always_ff @(posedge clk)
    begin
        if (tier_we)
            tier_mem[tier_addr] <= tier_wdata;
        else if (ctl.lookup)
            tier_rd_reg <= tier_mem[tier_addr];
    end

    always_ff @(posedge clk)
    begin
        if (present_we)
            present_mem[present_addr] <= present_wdata;
        else if (ctl.lookup)
            present_rd_reg <= present_mem[present_addr];
    end

    // list ends
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        if (ctl.unlink)
        begin
            if (!prev_rd_reg.ok)
                head_next[tier_rd_reg] = next_rd_reg;
            if (!next_rd_reg.ok)
                tail_next[tier_rd_reg] = prev_rd_reg;
        end
        if (ctl.link_a)
        begin
            if (!head_reg[tier_reg].ok)
                tail_next[tier_reg] = self_link;
            head_next[tier_reg] = self_link;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '{default: '0};
            tail_reg    <= '{default: '0};
            clr_cnt_reg <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            if (ctl.clear)
                clr_cnt_reg <= addr_t'(clr_cnt_reg + 1'b1);
            if (ctl.load_out)
                out_vld_reg <= 1'b1;
            else if (out_ready)
                out_vld_reg <= 1'b0;
        end
    end

    assign slc_node = tail_reg[0].ok ? tail_reg[0].node : '0;
    assign tlc_node = tail_reg[1].ok ? tail_reg[1].node : '0;

    always_ff @(posedge clk)
    begin
        if (ctl.load_out)
            out_data_reg <= {{(OUT_W - OUT_USED){1'b0}},
                             tail_reg[1].ok, tlc_node,
                             tail_reg[0].ok, slc_node,
                             err_reg};
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_data_reg;

    assign sts.clr_last = (clr_cnt_reg == addr_t'(NODE_COUNT - 1));
    assign sts.err      = pre_err_reg
                          | ((cmd_reg == CMD_WRITE) ? present_rd_reg : !present_rd_reg);
    assign sts.is_write = (cmd_reg == CMD_WRITE);
    assign sts.is_read  = (cmd_reg == CMD_READ);
    assign sts.out_free = !out_vld_reg || out_ready;

    `DTL_ASSERT_ALWAYS(a_slc_ends_agree, head_reg[0].ok == tail_reg[0].ok, "SLC head/tail mismatch")
    `DTL_ASSERT_ALWAYS(a_tlc_ends_agree, head_reg[1].ok == tail_reg[1].ok, "TLC head/tail mismatch")
    `DTL_ASSERT_NEXT(a_clr_hold, !ctl.clear, $stable(clr_cnt_reg), "clear counter moved")

endmodule

[design/dtlru_ctrl.sv]
// Controller: sequences clear pass, lookup, unlink, relink and result load.
`include "dual_tier_lru_eviction_lists_core_defines.svh"
module dtlru_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  dtlru_pkg::sts_t sts,
    output dtlru_pkg::ctl_t ctl
);
    import dtlru_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_LINK_A = 3'd3;
    localparam logic [2:0] S_LINK_B = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                ctl.clear = 1'b1;
                if (sts.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.lookup = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                ctl.check = 1'b1;
                if (sts.err)
                    state_next = S_DONE;
                else if (sts.is_write)
                begin
                    ctl.link_a = 1'b1;
                    state_next = S_LINK_B;
                end
                else
                begin
                    ctl.unlink = 1'b1;
                    state_next = sts.is_read ? S_LINK_A : S_DONE;
                end
            end
            S_LINK_A:
            begin
                ctl.link_a = 1'b1;
                state_next = S_LINK_B;
            end
            S_LINK_B:
            begin
                ctl.link_b = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    ctl.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    `DTL_ASSERT_NEXT(a_accept_to_check, in_valid && in_ready, state_reg == S_CHECK, "no check after transfer")
    `DTL_ASSERT_IMPL(a_link_b_order, ctl.link_b, $past(ctl.link_a), "relink out of order")
    `DTL_ASSERT_ALWAYS(a_one_update, !(ctl.unlink && ctl.link_a), "unlink and link overlap")

endmodule

[design/dual_tier_lru_eviction_lists_core.sv]
// Top level of the dual tier LRU eviction lists block.
//
//  channel   dir  width  transfer
//  s_axis    in   16     one command: command, node, tier
//  m_axis    out  24     one status per command: error and both tier tails
//
//  After reset a clear pass runs over every entry of the present memory;
//  s_axis_tready stays low during it.
//  Steps, set by the single-port prev/next link memories: lookup, check,
//  then unlink (remove), link_a+link_b (write), unlink+link_a+link_b (read)
//  or none (rejected), then result load; m_axis shows it the cycle after.
//  One command is worked at a time; the output register lets the next
//  command start while a result waits on m_axis_tready.
module dual_tier_lru_eviction_lists_core #(
    parameter int NODE_COUNT = dtlru_pkg::DEF_NODE_COUNT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // [1:0] command, [11:2] node, [12] tier
    input  logic [dtlru_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [0] error, [10:1] slc_lru_node, [11] slc_lru_valid,
    // [21:12] tlc_lru_node, [22] tlc_lru_valid
    output logic [dtlru_pkg::OUT_W-1:0] m_axis_tdata
);
    import dtlru_pkg::*;

    ctl_t ctl;
    sts_t sts;

    dtlru_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    dtlru_datapath #(
        .NODE_COUNT (NODE_COUNT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .sts       (sts),
        .in_data   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule
